>>> sv/bytecode_stack_executor_top_assert.svh
// Assertion macros for the bytecode stack executor.
`ifndef BYTECODE_STACK_EXECUTOR_TOP_ASSERT_SVH
`define BYTECODE_STACK_EXECUTOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSE_ASSERT(label, prop, msg)
`define BSE_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> sv/bse_pkg.sv
// Shared types, opcodes and constants for the bytecode stack executor.
package bse_pkg;
    localparam int StackDepth   = 64;
    localparam int TableEntries = 256;
    localparam int ValueBits    = 32;
    localparam int SpW  = $clog2(StackDepth);
    localparam int SdW  = $clog2(StackDepth + 1);
    localparam int TiW  = $clog2(TableEntries);

    localparam logic [3:0] OP_LDC   = 4'd0;
    localparam logic [3:0] OP_LDV   = 4'd1;
    localparam logic [3:0] OP_STV   = 4'd2;
    localparam logic [3:0] OP_JF    = 4'd3;
    localparam logic [3:0] OP_JT    = 4'd4;
    localparam logic [3:0] OP_JFWD  = 4'd5;
    localparam logic [3:0] OP_JABS  = 4'd6;
    localparam logic [3:0] OP_CMP   = 4'd7;
    localparam logic [3:0] OP_PRINT = 4'd8;
    localparam logic [3:0] OP_NL    = 4'd9;
    localparam logic [3:0] OP_ADD   = 4'd10;
    localparam logic [3:0] OP_MUL   = 4'd11;
    localparam logic [3:0] OP_DIV   = 4'd12;
    localparam logic [3:0] OP_MOD   = 4'd13;
    localparam logic [3:0] OP_SUB   = 4'd14;
    localparam logic [3:0] OP_SETC  = 4'd15;

    localparam logic [15:0] CMP_LT = 16'd0;
    localparam logic [15:0] CMP_LE = 16'd1;
    localparam logic [15:0] CMP_NE = 16'd3;
    localparam logic [15:0] CMP_GT = 16'd4;
    localparam logic [15:0] CMP_GE = 16'd5;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_UNDER = 3'd1;
    localparam logic [2:0] ERR_OVER  = 3'd2;
    localparam logic [2:0] ERR_DIV0  = 3'd3;
    localparam logic [2:0] ERR_INDEX = 3'd4;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [15:0]        arg;
        logic [15:0]        position;
        logic signed [31:0] const_value;
    } bse_in_t;

    typedef struct packed {
        logic [15:0]        next_position;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               newline;
        logic [2:0]         error;
    } bse_out_t;

    typedef struct packed {
        logic                 start;
        logic                 is_mod;
        logic [ValueBits-1:0] a;
        logic [ValueBits-1:0] b;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [ValueBits-1:0] result;
    } div_rsp_t;
endpackage

>>> sv/bse_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
module bse_div
    import bse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CntW = $clog2(ValueBits + 1);

    logic [ValueBits-1:0] quo_reg, quo_next;
    logic [ValueBits-1:0] rem_reg, rem_next;
    logic [ValueBits-1:0] dvs_reg, dvs_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 qneg_reg, qneg_next;
    logic                 rneg_reg, rneg_next;
    logic                 mod_reg, mod_next;
    logic [ValueBits:0]   trial;
    logic [ValueBits-1:0] quo_fin, rem_fin;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        mod_next  = mod_reg;
        trial     = {rem_reg, quo_reg[ValueBits-1]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            quo_next  = req.a[ValueBits-1] ? -req.a : req.a;
            dvs_next  = req.b[ValueBits-1] ? -req.b : req.b;
            rem_next  = '0;
            cnt_next  = CntW'(ValueBits);
            busy_next = 1'b1;
            qneg_next = req.a[ValueBits-1] ^ req.b[ValueBits-1];
            rneg_next = req.a[ValueBits-1];
            mod_next  = req.is_mod;
        end
        else if (busy_reg)
        begin
            if (trial[ValueBits])
                rem_next = {rem_reg[ValueBits-2:0], quo_reg[ValueBits-1]};
            else
                rem_next = trial[ValueBits-1:0];
            quo_next = {quo_reg[ValueBits-2:0], ~trial[ValueBits]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        mod_reg  <= mod_next;
    end

    assign quo_fin    = qneg_reg ? -quo_reg : quo_reg;
    assign rem_fin    = rneg_reg ? -rem_reg : rem_reg;
    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = mod_reg ? rem_fin : quo_fin;
endmodule

>>> sv/bytecode_stack_executor_top.sv
// Stack-machine executor: one instruction per request, stack and tables in RAM.
// An accepted request passes S_READ, S_EXEC and S_WRITE, then out_valid rises in S_OUT;
// div and mod wait in S_DIV for the 32-step divider. One request at a time: ready is
// low until the result is taken. Reset: stack empty; variable store cleared by a
// sweep over all 256 entries after reset, during which no request is accepted.
// Constant table is undefined until written.
module bytecode_stack_executor_top
    import bse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  bse_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output bse_out_t out_data
);
`include "bytecode_stack_executor_top_assert.svh"

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [SdW-1:0] depth_reg;
    logic [TiW:0]   clr_reg;
    bse_in_t        req_reg;
    bse_out_t       res_reg;
    logic [ValueBits-1:0] stk_mem [StackDepth];
    logic [ValueBits-1:0] var_mem [TableEntries];
    logic [ValueBits-1:0] con_mem [TableEntries];
    logic [ValueBits-1:0] top_q, sec_q, var_q, con_q;
    logic [ValueBits-1:0] val_reg;
    logic [2:0] err;
    logic [1:0] need;
    logic grow, idx_ok, uses_idx;
    logic [15:0] seq_pos;
    logic [15:0] next_pos;
    logic [SpW-1:0] top_idx, sec_idx;
    div_req_t dreq;
    div_rsp_t drsp;
    logic signed [ValueBits-1:0] sa, sb;
    logic cmp_r;
    logic [ValueBits-1:0] alu;
    logic push, pop1, pop2, do_push;

    // Read ports: stack top and next, variable, constant.
    assign top_idx = SpW'(depth_reg - 1'b1);
    assign sec_idx = SpW'(depth_reg - 2'd2);
    always_ff @(posedge clk)
    begin
        top_q <= stk_mem[top_idx];
        sec_q <= stk_mem[sec_idx];
        var_q <= var_mem[req_reg.arg[TiW-1:0]];
        con_q <= con_mem[req_reg.arg[TiW-1:0]];
    end

    assign need = (req_reg.cmd == OP_STV || req_reg.cmd == OP_JF ||
                   req_reg.cmd == OP_JT || req_reg.cmd == OP_PRINT) ? 2'd1 :
                  (req_reg.cmd == OP_CMP ||
                   (req_reg.cmd >= OP_ADD && req_reg.cmd <= OP_SUB)) ? 2'd2 : 2'd0;
    assign grow     = req_reg.cmd == OP_LDC || req_reg.cmd == OP_LDV;
    assign uses_idx = req_reg.cmd <= OP_STV || req_reg.cmd == OP_SETC;
    assign idx_ok   = req_reg.arg < 16'(TableEntries);
    assign seq_pos  = req_reg.position +
                      ((req_reg.cmd <= OP_CMP || req_reg.cmd == OP_SETC) ? 16'd2 : 16'd1);

    always_comb
    begin
        if (depth_reg < SdW'(need))
            err = ERR_UNDER;
        else if (grow && depth_reg >= SdW'(StackDepth))
            err = ERR_OVER;
        else if (uses_idx && !idx_ok)
            err = ERR_INDEX;
        else if ((req_reg.cmd == OP_DIV || req_reg.cmd == OP_MOD) && top_q == '0)
            err = ERR_DIV0;
        else
            err = ERR_OK;
    end

    // Jumps take the target only when the request raises no error.
    always_comb
    begin
        next_pos = seq_pos;
        if (err == ERR_OK)
        begin
            case (req_reg.cmd)
                OP_JF:   if (top_q == '0) next_pos = req_reg.arg;
                OP_JT:   if (top_q != '0) next_pos = req_reg.arg;
                OP_JFWD: next_pos = req_reg.position + req_reg.arg;
                OP_JABS: next_pos = req_reg.arg;
                default: ;
            endcase
        end
    end

    assign sa = sec_q;
    assign sb = top_q;
    always_comb
    begin
        case (req_reg.arg)
            CMP_LT:  cmp_r = sa < sb;
            CMP_LE:  cmp_r = sa <= sb;
            CMP_NE:  cmp_r = sa != sb;
            CMP_GT:  cmp_r = sa > sb;
            CMP_GE:  cmp_r = sa >= sb;
            default: cmp_r = sa == sb;
        endcase
    end

    // Shared arithmetic unit for the non-divide operations.
    always_comb
    begin
        case (req_reg.cmd)
            OP_LDC:  alu = con_q;
            OP_LDV:  alu = var_q;
            OP_CMP:  alu = ValueBits'(cmp_r);
            OP_ADD:  alu = sec_q + top_q;
            OP_SUB:  alu = sec_q - top_q;
            OP_MUL:  alu = ValueBits'(sec_q * top_q);
            default: alu = '0;
        endcase
    end

    assign pop1 = req_reg.cmd inside {OP_STV, OP_JF, OP_JT, OP_PRINT};
    assign pop2 = req_reg.cmd == OP_CMP || (req_reg.cmd >= OP_ADD && req_reg.cmd <= OP_SUB);
    assign push = grow || pop2;

    assign dreq.start  = state_reg == S_EXEC && err == ERR_OK &&
                         (req_reg.cmd == OP_DIV || req_reg.cmd == OP_MOD);
    assign dreq.is_mod = req_reg.cmd == OP_MOD;
    assign dreq.a      = sec_q;
    assign dreq.b      = top_q;

    bse_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == (TiW+1)'(TableEntries - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = dreq.start ? S_DIV : S_WRITE;
            S_DIV:   if (drsp.done) state_next = S_WRITE;
            S_WRITE: state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign do_push = state_reg == S_WRITE && res_reg.error == ERR_OK && push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            depth_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_WRITE && res_reg.error == ERR_OK)
            begin
                if (pop2)
                    depth_reg <= depth_reg - 1'b1;
                else if (grow)
                    depth_reg <= depth_reg + 1'b1;
                else if (pop1)
                    depth_reg <= depth_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            req_reg <= in_data;
        if (state_reg == S_CLEAR)
            var_mem[clr_reg[TiW-1:0]] <= '0;
        else if (state_reg == S_WRITE && res_reg.error == ERR_OK &&
                 req_reg.cmd == OP_STV)
            var_mem[req_reg.arg[TiW-1:0]] <= top_q;
        if (state_reg == S_WRITE && res_reg.error == ERR_OK &&
            req_reg.cmd == OP_SETC)
            con_mem[req_reg.arg[TiW-1:0]] <= req_reg.const_value;
        // Push writes the new top slot (over the lower popped operand for binary ops); depth still holds the old value.
        if (do_push)
            stk_mem[pop2 ? sec_idx : SpW'(depth_reg)] <= val_reg;
        if (state_reg == S_EXEC)
        begin
            val_reg <= alu;
            res_reg.error         <= err;
            res_reg.newline       <= err == ERR_OK && req_reg.cmd == OP_NL;
            res_reg.print_valid   <= err == ERR_OK && req_reg.cmd == OP_PRINT;
            res_reg.print_value   <= (err == ERR_OK && req_reg.cmd == OP_PRINT) ?
                                     top_q : '0;
            res_reg.next_position <= next_pos;
        end
        if (state_reg == S_DIV && drsp.done)
            val_reg <= drsp.result;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_data  = res_reg;

    `BSE_ASSERT(a_depth_max, depth_reg <= SdW'(StackDepth), "stack depth above limit")
    `BSE_ASSERT(a_err_no_print,
                out_valid && out_data.error != ERR_OK |-> !out_data.print_valid, "print on error")
    `BSE_ASSERT(a_div_busy, drsp.busy |-> state_reg == S_DIV, "divider busy outside divide")
    `BSE_ASSERT_RST(a_rst_idle, !rst_n |-> !in_ready && !out_valid, "handshake during reset")
endmodule
